/* rtl/dfe_pkg.sv */
`default_nettype none

package dfe_pkg;

  localparam int unsigned MAX_DELIM_BYTES_DEF = 4;
  localparam int unsigned LEN_BITS_DEF        = 12;
  localparam int unsigned FRAME_LEN_W         = 12;
  localparam int unsigned QUEUE_DEPTH         = 2;
  localparam int unsigned PADDR_W             = 5;

  localparam logic [31:0]            START_PATTERN_RST = 32'h0000_0024;
  localparam logic [2:0]             START_LENGTH_RST  = 3'd1;
  localparam logic [31:0]            END_PATTERN_RST   = 32'h0000_0D0A;
  localparam logic [2:0]             END_LENGTH_RST    = 3'd2;
  localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_LEN_RST = 12'd2048;

  typedef enum logic [2:0] {
    REG_START_PATTERN = 3'd0,
    REG_START_LENGTH  = 3'd1,
    REG_END_PATTERN   = 3'd2,
    REG_END_LENGTH    = 3'd3,
    REG_USE_START     = 3'd4,
    REG_USE_END       = 3'd5,
    REG_MAX_FRAME_LEN = 3'd6
  } dfe_reg_e;

  typedef struct packed {
    logic [31:0]            start_pattern;
    logic [2:0]             start_length;
    logic [31:0]            end_pattern;
    logic [2:0]             end_length;
    logic                   use_start;
    logic                   use_end;
    logic [FRAME_LEN_W-1:0] max_frame_len;
  } dfe_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic       frame_overflow;
  } dfe_result_t;

endpackage

`default_nettype wire

/* rtl/dfe_front.sv */
`default_nettype none

module dfe_front import dfe_pkg::*; #(
  parameter int unsigned MAX_DELIM_BYTES = MAX_DELIM_BYTES_DEF,
  parameter int unsigned LEN_BITS        = LEN_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dfe_cfg_t    cfg_i,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        q_space_i,
  output logic             q_push_o,
  output dfe_result_t      q_data_o
);

  localparam int unsigned WIN    = (MAX_DELIM_BYTES < 4) ? MAX_DELIM_BYTES : 4;
  localparam int unsigned FILL_W = $clog2(WIN + 1);
  localparam int unsigned CMP_W  = (LEN_BITS > FRAME_LEN_W) ? LEN_BITS : FRAME_LEN_W;
  localparam logic [LEN_BITS-1:0] COUNT_MAX = {LEN_BITS{1'b1}};
  localparam logic [FILL_W-1:0]   FILL_FULL = FILL_W'(WIN);
  localparam logic [FILL_W-1:0]   FILL_ONE  = FILL_W'(1);

  logic [8*WIN-1:0]    win_q, win_d, win_n;
  logic [8*WIN+7:0]    win_ext;
  logic [FILL_W-1:0]   fill_q, fill_d, fill_n;
  logic [FILL_W-1:0]   since_q, since_d, since_n;
  logic                in_pay_q, in_pay_d;
  logic [LEN_BITS-1:0] cnt_q, cnt_d;
  logic                drop_q, drop_d;

  logic [FILL_W-1:0]   ls, le, pay_len;
  logic                sm, em, end_hit;
  logic                do_pay, pay_match, at_limit;
  logic [7:0]          sel_byte;
  logic                accept;
  dfe_result_t         res;
  logic                res_vld;

  function automatic logic [FILL_W-1:0] clamp_len(input logic [2:0] n);
    logic [FILL_W-1:0] r;
    if (n == 3'd0) begin
      r = FILL_ONE;
    end else if (32'(n) > WIN) begin
      r = FILL_FULL;
    end else begin
      r = FILL_W'(n);
    end
    return r;
  endfunction

  assign rx_ready_o = q_space_i;
  assign accept     = rx_valid_i && q_space_i;
  assign win_ext    = {win_q, rx_byte_i};
  assign win_n      = win_ext[8*WIN-1:0];
  assign fill_n     = (fill_q == FILL_FULL) ? fill_q : fill_q + FILL_ONE;
  assign since_n    = (since_q == FILL_FULL) ? since_q : since_q + FILL_ONE;
  assign ls         = clamp_len(cfg_i.start_length);
  assign le         = clamp_len(cfg_i.end_length);
  assign at_limit   = (CMP_W'(cnt_q) >= CMP_W'(cfg_i.max_frame_len)) || (cnt_q == COUNT_MAX);

  // match the newest len bytes of the window against the pattern tail
  always_comb begin
    sm = 1'b1;
    em = 1'b1;
    for (int k = 0; k < WIN; k++) begin
      if (k < 32'(ls) && win_n[8*k +: 8] != cfg_i.start_pattern[8*k +: 8]) begin
        sm = 1'b0;
      end
      if (k < 32'(le) && win_n[8*k +: 8] != cfg_i.end_pattern[8*k +: 8]) begin
        em = 1'b0;
      end
    end
  end

  assign end_hit = (since_n >= le) && em;

  always_comb begin
    win_d     = win_n;
    fill_d    = fill_n;
    since_d   = since_n;
    in_pay_d  = in_pay_q;
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    res       = '0;
    res_vld   = 1'b0;
    do_pay    = 1'b0;
    pay_match = 1'b0;
    pay_len   = le;
    sel_byte  = 8'd0;

    if (!cfg_i.use_start && !cfg_i.use_end) begin
      res.out_byte   = rx_byte_i;
      res.byte_valid = 1'b1;
      res_vld        = 1'b1;
    end else if (!cfg_i.use_start) begin
      do_pay    = 1'b1;
      pay_len   = le;
      pay_match = (fill_n >= le) && em;
    end else if (!cfg_i.use_end) begin
      if (!in_pay_q) begin
        if ((fill_n >= ls) && sm) begin
          in_pay_d = 1'b1;
          fill_d   = '0;
          cnt_d    = '0;
          drop_d   = 1'b0;
        end
      end else begin
        do_pay    = 1'b1;
        pay_len   = ls;
        pay_match = (fill_n >= ls) && sm;
      end
    end else begin
      if (!in_pay_q) begin
        if (end_hit) begin
          since_d = '0;
          fill_d  = '0;
        end else if ((since_n >= ls) && sm) begin
          in_pay_d = 1'b1;
          fill_d   = '0;
          cnt_d    = '0;
          drop_d   = 1'b0;
        end
      end else if (end_hit) begin
        since_d  = '0;
        in_pay_d = 1'b0;
        if (fill_n < le) begin
          // end pattern overlaps the start pattern: record has no start
          fill_d = '0;
          cnt_d  = '0;
          drop_d = 1'b0;
        end else begin
          do_pay    = 1'b1;
          pay_match = 1'b1;
        end
      end else begin
        do_pay = 1'b1;
      end
    end

    // hold back len-1 bytes so delimiter bytes never leave the window
    for (int k = 0; k < WIN; k++) begin
      if (k + 1 == 32'(pay_len)) begin
        sel_byte = win_n[8*k +: 8];
      end
    end

    if (do_pay) begin
      if (pay_match) begin
        fill_d = '0;
        cnt_d  = '0;
        if (drop_q) begin
          drop_d = 1'b0;
        end else begin
          res.frame_end = 1'b1;
          res_vld       = 1'b1;
        end
      end else if (fill_n < pay_len || drop_q) begin
        res_vld = 1'b0;
      end else if (at_limit) begin
        drop_d             = 1'b1;
        res.frame_overflow = 1'b1;
        res_vld            = 1'b1;
      end else begin
        res.out_byte   = sel_byte;
        res.byte_valid = 1'b1;
        res_vld        = 1'b1;
        cnt_d          = cnt_q + {{(LEN_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

  assign q_push_o = accept && res_vld;
  assign q_data_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      fill_q   <= '0;
      since_q  <= '0;
      in_pay_q <= 1'b0;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
    end else if (accept) begin
      win_q    <= win_d;
      fill_q   <= fill_d;
      since_q  <= since_d;
      in_pay_q <= in_pay_d;
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/dfe_queue.sv */
`default_nettype none

module dfe_queue import dfe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire dfe_result_t push_data_i,
  output logic             space_o,
  output logic             avail_o,
  input  wire logic        pop_i,
  output dfe_result_t      pop_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  dfe_result_t      mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign space_o    = (cnt_q != CNT_FULL);
  assign avail_o    = (cnt_q != '0);
  assign do_push    = push_i && space_o;
  assign do_pop     = pop_i && avail_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/dfe_back.sv */
`default_nettype none

module dfe_back import dfe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_avail_i,
  input  wire dfe_result_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output dfe_result_t      out_data_o
);

  logic        valid_q;
  dfe_result_t data_q;
  logic        load;

  // refill the output register when it is empty or being taken
  assign load        = q_avail_i && (!valid_q || out_ready_i);
  assign q_pop_o     = load;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= q_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/delimited_frame_extractor.sv */
// Delimited frame extractor: turns a stream of received bytes into payload
// bytes with frame-end and overflow markers.
// Input channel: rx_valid_i / rx_ready_o / rx_byte_i, one byte per request.
// Output channel: out_valid_o / out_ready_i with out_byte_o, byte_valid_o,
// frame_end_o and frame_overflow_o. Each input byte gives zero or one result.
// Throughput is one byte per cycle while the queue has space; the classifier
// compares up to four pattern bytes in parallel in the cycle a byte is taken.
// A result is written into a two-entry queue when its byte is taken and is
// then loaded into the output register; the queue lets the classifier run on
// while the receiver stalls; the input only stalls once that queue is full.
// Mode, patterns, lengths and frame limit are set over the APB port at
// byte addresses 0x00..0x18 and should be written only while the block is
// idle. Reset clears the delimiter window, frame state, queue and output,
// and loads the default patterns ("$" start, CR LF end, pass-through mode,
// 2048-byte limit).
`default_nettype none

module delimited_frame_extractor import dfe_pkg::*; #(
  parameter int unsigned MAX_DELIM_BYTES = MAX_DELIM_BYTES_DEF,
  parameter int unsigned LEN_BITS        = LEN_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               rx_valid_i,
  output logic                    rx_ready_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    byte_valid_o,
  output logic                    frame_end_o,
  output logic                    frame_overflow_o
);

  dfe_cfg_t    cfg_q;
  dfe_reg_e    reg_sel;
  logic        wr_en;
  logic        q_space, q_push, q_avail, q_pop;
  dfe_result_t q_in, q_out, res_out;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = dfe_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_pattern <= START_PATTERN_RST;
      cfg_q.start_length  <= START_LENGTH_RST;
      cfg_q.end_pattern   <= END_PATTERN_RST;
      cfg_q.end_length    <= END_LENGTH_RST;
      cfg_q.use_start     <= 1'b0;
      cfg_q.use_end       <= 1'b0;
      cfg_q.max_frame_len <= MAX_FRAME_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_START_PATTERN: cfg_q.start_pattern <= pwdata;
        REG_START_LENGTH:  cfg_q.start_length  <= pwdata[2:0];
        REG_END_PATTERN:   cfg_q.end_pattern   <= pwdata;
        REG_END_LENGTH:    cfg_q.end_length    <= pwdata[2:0];
        REG_USE_START:     cfg_q.use_start     <= pwdata[0];
        REG_USE_END:       cfg_q.use_end       <= pwdata[0];
        REG_MAX_FRAME_LEN: cfg_q.max_frame_len <= pwdata[FRAME_LEN_W-1:0];
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START_PATTERN: prdata = cfg_q.start_pattern;
      REG_START_LENGTH:  prdata = {29'd0, cfg_q.start_length};
      REG_END_PATTERN:   prdata = cfg_q.end_pattern;
      REG_END_LENGTH:    prdata = {29'd0, cfg_q.end_length};
      REG_USE_START:     prdata = {31'd0, cfg_q.use_start};
      REG_USE_END:       prdata = {31'd0, cfg_q.use_end};
      REG_MAX_FRAME_LEN: prdata = {{(32-FRAME_LEN_W){1'b0}}, cfg_q.max_frame_len};
      default:           prdata = 32'd0;
    endcase
  end

  dfe_front #(
    .MAX_DELIM_BYTES (MAX_DELIM_BYTES),
    .LEN_BITS        (LEN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_space_i  (q_space),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  dfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .space_o     (q_space),
    .avail_o     (q_avail),
    .pop_i       (q_pop),
    .pop_data_o  (q_out)
  );

  dfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_avail_i   (q_avail),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res_out)
  );

  assign out_byte_o       = res_out.out_byte;
  assign byte_valid_o     = res_out.byte_valid;
  assign frame_end_o      = res_out.frame_end;
  assign frame_overflow_o = res_out.frame_overflow;

endmodule

`default_nettype wire

/* bench/tb_delimited_frame_extractor.sv */
`default_nettype none

module tb_delimited_frame_extractor;
  import dfe_pkg::*;

  localparam int unsigned WIN_BYTES = 4;
  localparam int unsigned COUNT_MAX = 4095;

  class frame_scoreboard;
    logic [31:0] start_pattern;
    logic [2:0]  start_length;
    logic [31:0] end_pattern;
    logic [2:0]  end_length;
    bit          use_start;
    bit          use_end;
    logic [11:0] max_frame_len;

    logic [31:0] history;
    int unsigned window_fill;
    int unsigned since_end;
    bit          in_payload;
    bit          dropping;
    int unsigned payload_count;

    dfe_result_t pending_results[$];
    int unsigned failures;

    function new();
      start_pattern = START_PATTERN_RST;
      start_length  = START_LENGTH_RST;
      end_pattern   = END_PATTERN_RST;
      end_length    = END_LENGTH_RST;
      use_start     = 1'b0;
      use_end       = 1'b0;
      max_frame_len = MAX_FRAME_LEN_RST;
      history       = '0;
      window_fill   = 0;
      since_end     = 0;
      in_payload    = 1'b0;
      dropping      = 1'b0;
      payload_count = 0;
      failures      = 0;
    endfunction

    function void set_reg(dfe_reg_e idx, logic [31:0] value);
      case (idx)
        REG_START_PATTERN: start_pattern = value;
        REG_START_LENGTH:  start_length  = value[2:0];
        REG_END_PATTERN:   end_pattern   = value;
        REG_END_LENGTH:    end_length    = value[2:0];
        REG_USE_START:     use_start     = value[0];
        REG_USE_END:       use_end       = value[0];
        REG_MAX_FRAME_LEN: max_frame_len = value[11:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_len(logic [2:0] n);
      if (n == 0) return 1;
      if (n > WIN_BYTES) return WIN_BYTES;
      return n;
    endfunction

    function bit tail_match(logic [31:0] pattern, int unsigned len);
      logic [63:0] mask;
      mask = (64'd1 << (8 * len)) - 64'd1;
      return (history & mask[31:0]) == (pattern & mask[31:0]);
    endfunction

    function void enter_payload();
      in_payload    = 1'b1;
      window_fill   = 0;
      payload_count = 0;
      dropping      = 1'b0;
    endfunction

    // Payload path with a terminating delimiter of len bytes held back.
    function bit frame_step(int unsigned len, bit matched, output dfe_result_t r);
      r = '0;
      if (matched) begin
        window_fill   = 0;
        payload_count = 0;
        if (dropping) begin
          dropping = 1'b0;
          return 1'b0;
        end
        r.frame_end = 1'b1;
        return 1'b1;
      end
      if (window_fill < len || dropping) return 1'b0;
      if (payload_count >= max_frame_len) begin
        dropping = 1'b1;
        r.frame_overflow = 1'b1;
        return 1'b1;
      end
      r.out_byte   = 8'(history >> (8 * (len - 1)));
      r.byte_valid = 1'b1;
      payload_count = (payload_count + 1) & COUNT_MAX;
      return 1'b1;
    endfunction

    function void note_request(logic [7:0] b);
      int unsigned ls;
      int unsigned le;
      bit          sm;
      bit          em;
      bit          end_hit;
      bit          has;
      dfe_result_t r;
      ls  = clamp_len(start_length);
      le  = clamp_len(end_length);
      has = 1'b0;
      r   = '0;
      history = {history[23:0], b};
      if (window_fill < WIN_BYTES) window_fill++;
      if (since_end < WIN_BYTES) since_end++;
      sm = tail_match(start_pattern, ls);
      em = tail_match(end_pattern, le);
      if (!use_start && !use_end) begin
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        has = 1'b1;
      end else if (use_end && !use_start) begin
        has = frame_step(le, window_fill >= le && em, r);
      end else if (use_start && !use_end) begin
        if (!in_payload) begin
          if (window_fill >= ls && sm) enter_payload();
        end else begin
          has = frame_step(ls, window_fill >= ls && sm, r);
        end
      end else begin
        end_hit = since_end >= le && em;
        if (!in_payload) begin
          if (end_hit) begin
            since_end   = 0;
            window_fill = 0;
          end else if (since_end >= ls && sm) begin
            enter_payload();
          end
        end else if (end_hit) begin
          since_end  = 0;
          in_payload = 1'b0;
          // end overlaps the start: record carries no start
          if (window_fill < le) begin
            window_fill   = 0;
            payload_count = 0;
            dropping      = 1'b0;
          end else begin
            has = frame_step(le, 1'b1, r);
          end
        end else begin
          has = frame_step(le, 1'b0, r);
        end
      end
      if (has) pending_results.push_back(r);
    endfunction

    function void check_result(dfe_result_t got);
      dfe_result_t exp;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: byte %02h valid %0b end %0b overflow %0b",
                   got.out_byte, got.byte_valid, got.frame_end, got.frame_overflow);
        return;
      end
      exp = pending_results.pop_front();
      if (got.out_byte !== exp.out_byte || got.byte_valid !== exp.byte_valid ||
          got.frame_end !== exp.frame_end || got.frame_overflow !== exp.frame_overflow) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                   exp.out_byte, exp.byte_valid, exp.frame_end, exp.frame_overflow,
                   got.out_byte, got.byte_valid, got.frame_end, got.frame_overflow);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               rx_valid_i;
  logic               rx_ready_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         out_byte_o;
  logic               byte_valid_o;
  logic               frame_end_o;
  logic               frame_overflow_o;

  frame_scoreboard sb;

  int unsigned burst_left;
  bit          quiet;
  int unsigned items_sent;
  bit          hold_off_req;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned stall_mode;
  logic [7:0]  stall_mask;

  delimited_frame_extractor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .frame_end_o      (frame_end_o),
    .frame_overflow_o (frame_overflow_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(dfe_result_t'({out_byte_o, byte_valid_o, frame_end_o,
                                       frame_overflow_o}));
      if (rx_valid_i && rx_ready_o) sb.note_request(rx_byte_i);
    end
  end

  // Receiver: random stall patterns, plus a long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    stall_left  = 0;
    stall_mode  = 0;
    stall_mask  = '0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        if (stall_left == 0) begin
          stall_left = $urandom_range(20, 120);
          stall_mode = $urandom_range(0, 3);
          stall_mask = 8'($urandom);
        end
        stall_left--;
        stall_mask = {stall_mask[6:0], stall_mask[7]};
        case (stall_mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = stall_mask[0];
          2:       out_ready_i = 1'($urandom_range(0, 1));
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!quiet) begin
        rx_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
    burst_left--;
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!rx_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold off until every expected result is out and the pipeline is empty.
  task automatic drain();
    rx_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input dfe_reg_e idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] sp, input logic [2:0] sl,
                               input logic [31:0] ep, input logic [2:0] el,
                               input bit us, input bit ue, input logic [11:0] mfl);
    drain();
    write_reg(REG_START_PATTERN, sp);
    write_reg(REG_START_LENGTH, {29'd0, sl});
    write_reg(REG_END_PATTERN, ep);
    write_reg(REG_END_LENGTH, {29'd0, el});
    write_reg(REG_USE_START, {31'd0, us});
    write_reg(REG_USE_END, {31'd0, ue});
    write_reg(REG_MAX_FRAME_LEN, {20'd0, mfl});
  endtask

  function automatic logic [7:0] delim_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h24;
      1:       return 8'h0D;
      2:       return 8'h0A;
      default: return 8'h7E;
    endcase
  endfunction

  function automatic logic [31:0] rand_pattern();
    logic [31:0] p;
    for (int i = 0; i < 4; i++)
      p[8*i +: 8] = $urandom_range(0, 1) ? delim_byte() : 8'($urandom_range(0, 255));
    return p;
  endfunction

  function automatic logic [2:0] rand_len();
    if ($urandom_range(0, 3) == 0) return 3'($urandom_range(0, 7));
    return 3'($urandom_range(1, 4));
  endfunction

  // Favor delimiter bytes so partial and overlapping matches show up.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return sb.start_pattern[8*$urandom_range(0, 3) +: 8];
    if (r < 5) return sb.end_pattern[8*$urandom_range(0, 3) +: 8];
    if (r < 6) return delim_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pattern(input logic [31:0] pattern, input logic [2:0] len_raw,
                              input bit partial);
    int n;
    n = sb.clamp_len(len_raw);
    for (int k = n - 1; k >= (partial ? 1 : 0); k--) send_byte(pattern[8*k +: 8]);
    if (partial) send_byte(pick_byte());
  endtask

  task automatic gen_traffic(input int n);
    int unsigned first;
    int unsigned kind;
    int unsigned plen;
    first = items_sent;
    while (items_sent - first < n) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind == 1) begin
        if ($urandom_range(0, 1)) send_pattern(sb.start_pattern, sb.start_length, 1'b1);
        else send_pattern(sb.end_pattern, sb.end_length, 1'b1);
      end else begin
        if (sb.use_start && sb.use_end)
          repeat ($urandom_range(0, 2)) send_byte(pick_byte());
        if (sb.use_start) send_pattern(sb.start_pattern, sb.start_length, 1'b0);
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 8);
        repeat (plen) send_byte(pick_byte());
        if (sb.use_end) send_pattern(sb.end_pattern, sb.end_length, 1'b0);
      end
    end
  endtask

  task automatic random_phase(input bit us, input bit ue, input int n, input int variant);
    logic [31:0] sp;
    logic [31:0] ep;
    logic [2:0]  sl;
    logic [2:0]  el;
    logic [11:0] mfl;
    sp = rand_pattern();
    ep = rand_pattern();
    sl = rand_len();
    el = rand_len();
    case ($urandom_range(0, 5))
      0:       mfl = 12'd0;
      1:       mfl = 12'd1;
      2:       mfl = 12'hFFF;
      default: mfl = 12'($urandom_range(2, 12));
    endcase
    if (variant == 1) begin
      sp = 32'h0000_0000;
      ep = 32'hFFFF_FFFF;
      sl = 3'd7;
      el = 3'd0;
    end else if (variant == 2) begin
      sp = 32'hFFFF_FFFF;
      ep = 32'h0000_0000;
      sl = 3'd0;
      el = 3'd5;
    end
    apply_setting(sp, sl, ep, el, us, ue, mfl);
    quiet = ($urandom_range(0, 3) == 0);
    gen_traffic(n);
    quiet = 1'b0;
  endtask

  initial begin
    sb           = new();
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rx_valid_i   = 1'b0;
    rx_byte_i    = '0;
    burst_left   = 0;
    quiet        = 1'b0;
    items_sent   = 0;
    hold_off_req = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // pass-through, byte extremes
    apply_setting(32'h24, 3'd1, 32'h0D0A, 3'd2, 1'b0, 1'b0, 12'd2048);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);

    // terminator only: empty frame, normal frame, overflow and its dropped end
    apply_setting(32'h24, 3'd1, 32'h0D0A, 3'd2, 1'b0, 1'b1, 12'd2);
    send_text("\r\nAB\r\n123\r\n");

    // zero limit flags overflow on the first byte
    apply_setting(32'h24, 3'd1, 32'h0A, 3'd1, 1'b0, 1'b1, 12'd0);
    send_text("X\n");

    // combined: record without start, later start kept as payload
    apply_setting(32'h24, 3'd1, 32'h0D0A, 3'd2, 1'b1, 1'b1, 12'd2048);
    send_text("\r\n$a$\r\n");

    // starter only
    apply_setting(32'h24, 3'd1, 32'h0D0A, 3'd2, 1'b1, 1'b0, 12'd2048);
    send_text("q$a$");

    // long receiver hold-off while the sender keeps pushing
    apply_setting(rand_pattern(), 3'd3, rand_pattern(), 3'd4, 1'b0, 1'b0, 12'hFFF);
    hold_off_req = 1'b1;
    quiet = 1'b1;
    gen_traffic(60);
    quiet = 1'b0;

    for (int p = 0; p < 12; p++) random_phase(p[1], p[0], 90, 0);
    random_phase(1'b1, 1'b1, 40, 1);
    random_phase(1'b0, 1'b1, 40, 2);

    drain();
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
